### rtl/cfs_pkg.sv
// shared types, constants and helpers for the capture filter and statistics block
`timescale 1ns / 1ps
`default_nettype none

package cfs_pkg;

  // buffer size in packets and counter widths
  localparam int BUF_DEPTH = 1024;
  localparam int CNT_W     = 11;
  localparam int WIDE_W    = 32;
  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 16;
  localparam int DEPTH_W   = $clog2(BUF_DEPTH + 1) + 1;

  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [WIDE_W-1:0] WIDE_MAX      = '1;
  localparam logic signed [7:0] START_STRONG  = -8'sd100;
  localparam logic signed [7:0] MIN_RSSI_RST  = -8'sd100;
  localparam logic [4:0]        TYPE_MASK_RST = 5'b11111;

  // input item opcodes
  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  // packet kinds
  typedef enum logic [2:0] {
    KIND_WIFI_DATA = 3'd0,
    KIND_WIFI_MGMT = 3'd1,
    KIND_BEACON    = 3'd2,
    KIND_BLE_ADV   = 3'd3,
    KIND_BLE_DATA  = 3'd4
  } kind_t;

  // result verdicts
  typedef enum logic [2:0] {
    VD_IDLE     = 3'd0,
    VD_FILTERED = 3'd1,
    VD_STORED   = 3'd2,
    VD_DROPPED  = 3'd3,
    VD_CMD_DONE = 3'd4
  } verdict_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TYPE_MASK  = 3'd0,
    CFG_MIN_RSSI   = 3'd1,
    CFG_CHANNEL    = 3'd2,
    CFG_MAC_ON     = 3'd3,
    CFG_FILTER_MAC = 3'd4
  } cfg_idx_t;

  // classified item handed from the front end to the statistics engine
  typedef struct packed {
    opcode_t           opcode;
    logic              pass;
    logic [2:0]        kind;
    logic signed [7:0] rssi;
    logic [LEN_W-1:0]  len;
  } item_t;

  // one result record
  typedef struct packed {
    verdict_t            verdict;
    logic [CNT_W-1:0]    stored;
    logic [WIDE_W-1:0]   dropped;
    logic [CNT_W-1:0]    wifi;
    logic [CNT_W-1:0]    ble;
    logic [CNT_W-1:0]    data;
    logic [CNT_W-1:0]    mgmt;
    logic [CNT_W-1:0]    beacon;
    logic [WIDE_W-1:0]   bytes;
    logic signed [7:0]   strongest;
    logic signed [7:0]   weakest;
    logic signed [7:0]   avg;
  } result_t;

  // saturating increment for the packet counters
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

### rtl/cfs_classify.sv
// front end: configuration registers and per-packet filter decision
`timescale 1ns / 1ps
`default_nettype none

module cfs_classify (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // configuration writes
  input  wire logic                      cfg_valid,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [cfs_pkg::ADDR_W-1:0] cfg_data,
  // raw input fields
  input  wire logic [1:0]                opcode,
  input  wire logic [2:0]                pkt_kind,
  input  wire logic signed [7:0]         rssi,
  input  wire logic [7:0]                chan,
  input  wire logic [cfs_pkg::ADDR_W-1:0] src_address,
  input  wire logic [cfs_pkg::ADDR_W-1:0] dst_address,
  input  wire logic [cfs_pkg::LEN_W-1:0] pkt_length,
  // classified item
  output cfs_pkg::item_t                 item
);
  import cfs_pkg::*;

  logic [4:0]        type_mask_r;
  logic signed [7:0] min_rssi_r;
  logic [7:0]        channel_r;
  logic              mac_on_r;
  logic [ADDR_W-1:0] filter_mac_r;

  logic [7:0] mask_ext;
  logic       kind_ok;
  logic       rssi_ok;
  logic       chan_ok;
  logic       mac_ok;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_mask_r  <= TYPE_MASK_RST;
      min_rssi_r   <= MIN_RSSI_RST;
      channel_r    <= '0;
      mac_on_r     <= 1'b0;
      filter_mac_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TYPE_MASK:  type_mask_r  <= cfg_data[4:0];
        CFG_MIN_RSSI:   min_rssi_r   <= cfg_data[7:0];
        CFG_CHANNEL:    channel_r    <= cfg_data[7:0];
        CFG_MAC_ON:     mac_on_r     <= cfg_data[0];
        CFG_FILTER_MAC: filter_mac_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter terms; unknown kinds see a zero enable bit
  always_comb begin
    mask_ext = {3'b000, type_mask_r};
    kind_ok  = mask_ext[pkt_kind];
    rssi_ok  = (rssi >= min_rssi_r);
    chan_ok  = (channel_r == 8'd0) || (chan == channel_r);
    mac_ok   = !mac_on_r || (src_address == filter_mac_r) || (dst_address == filter_mac_r);
  end

  // classified record
  always_comb begin
    item.opcode = opcode_t'(opcode);
    item.pass   = kind_ok && rssi_ok && chan_ok && mac_ok;
    item.kind   = pkt_kind;
    item.rssi   = rssi;
    item.len    = pkt_length;
  end

endmodule

`default_nettype wire

### rtl/cfs_queue.sv
// two-entry queue between the classifier and the statistics engine
`timescale 1ns / 1ps
`default_nettype none

module cfs_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  cfs_pkg::item_t      push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output cfs_pkg::item_t      head
);
  import cfs_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign full      = count_r[1];
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### rtl/cfs_stats.sv
// back end: capture state, statistics counters and the result register
`timescale 1ns / 1ps
`default_nettype none

module cfs_stats (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_valid,
  input  cfs_pkg::item_t item,
  output logic           item_pop,
  output logic           res_valid,
  input  wire logic      res_ready,
  output cfs_pkg::result_t res
);
  import cfs_pkg::*;

  logic              capturing_r, capturing_nxt;
  logic [CNT_W-1:0]  stored_r, stored_nxt;
  logic [WIDE_W-1:0] dropped_r, dropped_nxt;
  logic [CNT_W-1:0]  wifi_r, wifi_nxt;
  logic [CNT_W-1:0]  ble_r, ble_nxt;
  logic [CNT_W-1:0]  data_r, data_nxt;
  logic [CNT_W-1:0]  mgmt_r, mgmt_nxt;
  logic [CNT_W-1:0]  beacon_r, beacon_nxt;
  logic [WIDE_W-1:0] bytes_r, bytes_nxt;
  logic signed [7:0] strong_r, strong_nxt;
  logic signed [7:0] weak_r, weak_nxt;
  logic signed [7:0] avg_r, avg_nxt;
  verdict_t          verdict;

  logic              res_valid_r, res_valid_nxt;
  result_t           res_r;

  logic              buf_full;
  logic [WIDE_W:0]   byte_sum;
  logic signed [8:0] rssi_sum;
  logic signed [8:0] rssi_adj;

  // take the next item when the result register is free or being emptied
  assign item_pop = item_valid && (!res_valid_r || res_ready);

  // helper arithmetic for a stored packet
  always_comb begin
    buf_full = ({{(DEPTH_W-CNT_W){1'b0}}, stored_r} >= DEPTH_W'(BUF_DEPTH));
    byte_sum = {1'b0, bytes_r} + {{(WIDE_W+1-LEN_W){1'b0}}, item.len};
    rssi_sum = {avg_r[7], avg_r} + {item.rssi[7], item.rssi};
    rssi_adj = rssi_sum + $signed({8'b0, rssi_sum[8]});
  end

  // state update for one item
  always_comb begin
    capturing_nxt = capturing_r;
    stored_nxt    = stored_r;
    dropped_nxt   = dropped_r;
    wifi_nxt      = wifi_r;
    ble_nxt       = ble_r;
    data_nxt      = data_r;
    mgmt_nxt      = mgmt_r;
    beacon_nxt    = beacon_r;
    bytes_nxt     = bytes_r;
    strong_nxt    = strong_r;
    weak_nxt      = weak_r;
    avg_nxt       = avg_r;
    verdict       = VD_CMD_DONE;
    unique case (item.opcode)
      OP_PACKET: begin
        if (!capturing_r) begin
          verdict = VD_IDLE;
        end else if (!item.pass) begin
          verdict = VD_FILTERED;
        end else if (buf_full) begin
          verdict = VD_DROPPED;
          if (dropped_r != WIDE_MAX) begin
            dropped_nxt = dropped_r + WIDE_W'(1);
          end
        end else begin
          verdict    = VD_STORED;
          stored_nxt = sat_inc(stored_r);
          bytes_nxt  = byte_sum[WIDE_W] ? WIDE_MAX : byte_sum[WIDE_W-1:0];
          if (item.kind <= KIND_BEACON) begin
            wifi_nxt = sat_inc(wifi_r);
            unique case (item.kind)
              KIND_WIFI_DATA: data_nxt   = sat_inc(data_r);
              KIND_WIFI_MGMT: mgmt_nxt   = sat_inc(mgmt_r);
              default:        beacon_nxt = sat_inc(beacon_r);
            endcase
          end else begin
            ble_nxt = sat_inc(ble_r);
          end
          if (item.rssi > strong_r) begin
            strong_nxt = item.rssi;
          end
          if (item.rssi < weak_r) begin
            weak_nxt = item.rssi;
          end
          avg_nxt = (avg_r == 8'sd0) ? item.rssi : rssi_adj[8:1];
        end
      end
      OP_START: begin
        if (!capturing_r) begin
          capturing_nxt = 1'b1;
          stored_nxt    = '0;
          dropped_nxt   = '0;
          wifi_nxt      = '0;
          ble_nxt       = '0;
          data_nxt      = '0;
          mgmt_nxt      = '0;
          beacon_nxt    = '0;
          bytes_nxt     = '0;
          strong_nxt    = START_STRONG;
          weak_nxt      = '0;
          avg_nxt       = '0;
        end
      end
      OP_STOP: begin
        capturing_nxt = 1'b0;
      end
      OP_CLEAR: begin
        stored_nxt  = '0;
        dropped_nxt = '0;
        wifi_nxt    = '0;
        ble_nxt     = '0;
        data_nxt    = '0;
        mgmt_nxt    = '0;
        beacon_nxt  = '0;
        bytes_nxt   = '0;
        strong_nxt  = '0;
        weak_nxt    = '0;
        avg_nxt     = '0;
      end
    endcase
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      stored_r    <= '0;
      dropped_r   <= '0;
      wifi_r      <= '0;
      ble_r       <= '0;
      data_r      <= '0;
      mgmt_r      <= '0;
      beacon_r    <= '0;
      bytes_r     <= '0;
      strong_r    <= '0;
      weak_r      <= '0;
      avg_r       <= '0;
    end else if (item_pop) begin
      capturing_r <= capturing_nxt;
      stored_r    <= stored_nxt;
      dropped_r   <= dropped_nxt;
      wifi_r      <= wifi_nxt;
      ble_r       <= ble_nxt;
      data_r      <= data_nxt;
      mgmt_r      <= mgmt_nxt;
      beacon_r    <= beacon_nxt;
      bytes_r     <= bytes_nxt;
      strong_r    <= strong_nxt;
      weak_r      <= weak_nxt;
      avg_r       <= avg_nxt;
    end
  end

  // result register valid flag
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (item_pop) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  // result payload, snapshot after the update
  always_ff @(posedge clk) begin
    if (item_pop) begin
      res_r.verdict   <= verdict;
      res_r.stored    <= stored_nxt;
      res_r.dropped   <= dropped_nxt;
      res_r.wifi      <= wifi_nxt;
      res_r.ble       <= ble_nxt;
      res_r.data      <= data_nxt;
      res_r.mgmt      <= mgmt_nxt;
      res_r.beacon    <= beacon_nxt;
      res_r.bytes     <= bytes_nxt;
      res_r.strongest <= strong_nxt;
      res_r.weakest   <= weak_nxt;
      res_r.avg       <= avg_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### rtl/capture_filter_and_stats_top.sv
// top level of the capture filter and statistics block
`timescale 1ns / 1ps
`default_nettype none

// Packet capture filter with running statistics. Commands (start, stop, clear) and packet
// descriptors arrive on the input stream, the opcode in in_tuser. A front end checks each
// packet against the configured type mask, minimum RSSI, channel and address filter and
// pushes the classified item into a two-entry queue; the statistics engine pops one item
// per cycle while the result register is free or being emptied, updates the counters and
// loads one result (verdict in out_tuser, snapshot of all statistics in out_tdata) into an
// output register. Every item yields exactly one result. Throughput is one item per clock
// while out_tready stays high; each item is held in a queue entry and then loaded into the
// result register. Configuration writes are always accepted and must only be issued while
// no item is in flight.

module capture_filter_and_stats_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [2:0] pkt_kind, [10:3] rssi, [18:11] chan, [66:19] src_address,
  // [114:67] dst_address, [130:115] pkt_length, [135:131] zero
  input  wire logic [135:0] in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]   in_tuser,
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [10:0] stored_total, [42:11] dropped_total, [53:43] wifi_total, [64:54] ble_total,
  // [75:65] wifi_data_total, [86:76] mgmt_frames, [97:87] beacon_frames,
  // [129:98] byte_total, [137:130] strongest, [145:138] weakest, [153:146] avg_rssi,
  // [159:154] zero
  output logic [159:0]      out_tdata,
  // [2:0] verdict
  output logic [2:0]        out_tuser,
  // configuration write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [47:0]  cfg_data
);
  import cfs_pkg::*;

  item_t   cls_item;
  item_t   q_head;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    in_xfer;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_xfer   = in_tvalid && in_tready;

  // front end
  cfs_classify u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (in_tuser),
    .pkt_kind    (in_tdata[2:0]),
    .rssi        (in_tdata[10:3]),
    .chan        (in_tdata[18:11]),
    .src_address (in_tdata[66:19]),
    .dst_address (in_tdata[114:67]),
    .pkt_length  (in_tdata[130:115]),
    .item        (cls_item)
  );

  // decoupling queue
  cfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_item (cls_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // statistics engine
  cfs_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_not_empty),
    .item       (q_head),
    .item_pop   (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // result packing
  assign out_tuser = res.verdict;
  assign out_tdata = {6'b0, res.avg, res.weakest, res.strongest, res.bytes, res.beacon,
                      res.mgmt, res.data, res.ble, res.wifi, res.dropped, res.stored};

endmodule

`default_nettype wire
